// File: src/dsa_pkg.sv
// Shared types and constants of the descriptor slot allocator.
package dsa_pkg;

    localparam int SLOT_W   = 10;
    localparam int CAP_W    = 11;
    localparam int STRIDE_W = 11;
    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 3;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W   = 2;
    localparam int PROD_W   = CAP_W + STRIDE_W;

    localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REINIT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 3'd5;

    localparam logic [KIND_W-1:0] HK_VIEWS    = 2'd0;
    localparam logic [KIND_W-1:0] HK_SAMPLERS = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] free_index;
        logic              handle_valid;
    } dsa_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [ADDR_W-1:0]   cpu_address;
        logic [ADDR_W-1:0]   gpu_address;
        logic                gpu_address_valid;
        logic [CAP_W-1:0]    used_count;
    } dsa_rsp_t;

    // Decision made at accept, carried alongside the free-list read.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                alloc_ok;
        logic                from_ram;
        logic [CAP_W-1:0]    pos;
        logic [CAP_W-1:0]    used;
    } dsa_s1_t;

endpackage

// File: src/dsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsa_ram
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dsa_ctrl.sv
// Stack control: used count, fill mark, free-list access and first pipeline stage.
module dsa_ctrl
    import dsa_pkg::*;
#(
    parameter int CAPACITY_MAX = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  dsa_req_t                         req,
    input  logic [CAP_W-1:0]                 capacity_in_use,
    input  logic                             adv,
    output logic                             s1_valid,
    output dsa_s1_t                          s1,
    output logic                             ram_we,
    output logic [$clog2(CAPACITY_MAX)-1:0]  ram_waddr,
    output logic [((($clog2(CAPACITY_MAX)) < CAP_W) ? $clog2(CAPACITY_MAX) : CAP_W)-1:0]
                                             ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(CAPACITY_MAX)-1:0]  ram_raddr
);

    localparam int AW      = $clog2(CAPACITY_MAX);
    localparam int ENT_W   = (AW < CAP_W) ? AW : CAP_W;
    localparam int CAP_LIM = (CAPACITY_MAX < 2047) ? CAPACITY_MAX : 2047;
    localparam logic [CAP_W-1:0] CAP_LIM_V = CAP_W'(CAP_LIM);

    logic [CAP_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] mark_reg, mark_next;
    logic             s1_valid_reg;
    dsa_s1_t          s1_reg, s1_next;
    logic [CAP_W-1:0] cap;
    logic             s1_en;
    logic             accept;

    assign cap       = (capacity_in_use > CAP_LIM_V) ? CAP_LIM_V : capacity_in_use;
    assign s1_en     = !s1_valid_reg || adv;
    assign req_stall = !s1_en;
    assign accept    = req_valid && s1_en;
    assign ram_re    = accept;
    assign ram_raddr = AW'(count_reg);

    always_comb
    begin
        count_next       = count_reg;
        mark_next        = mark_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(count_reg);
        ram_wdata        = ENT_W'(count_reg);
        s1_next.status   = ST_OK;
        s1_next.alloc_ok = 1'b0;
        s1_next.from_ram = 1'b0;
        s1_next.pos      = count_reg;
        if (accept)
        begin
            unique case (req.func)
                FN_ALLOC:
                begin
                    if (count_reg >= cap)
                    begin
                        s1_next.status = ST_FULL;
                    end
                    else
                    begin
                        s1_next.alloc_ok = 1'b1;
                        count_next       = count_reg + CAP_W'(1);
                        if (count_reg < mark_reg)
                        begin
                            s1_next.from_ram = 1'b1;
                        end
                        else
                        begin
                            // at or past the fill mark: slot is its own position
                            ram_we    = 1'b1;
                            mark_next = count_reg + CAP_W'(1);
                        end
                    end
                end
                FN_FREE:
                begin
                    if (!req.handle_valid)
                    begin
                        s1_next.status = ST_IGNORED;
                    end
                    else if (count_reg == '0)
                    begin
                        s1_next.status = ST_EMPTY;
                    end
                    else if (CAP_W'(req.free_index) >= cap)
                    begin
                        s1_next.status = ST_RANGE;
                    end
                    else
                    begin
                        count_next = count_reg - CAP_W'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = AW'(count_reg - CAP_W'(1));
                        ram_wdata  = ENT_W'(req.free_index);
                    end
                end
                FN_REINIT:
                begin
                    count_next = '0;
                    mark_next  = '0;
                end
                default:
                begin
                    s1_next.status = ST_IGNORED;
                end
            endcase
        end
        s1_next.used = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            mark_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            mark_reg  <= mark_next;
            if (s1_en)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    a_count_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mark_reg)
        else $error("used count above fill mark");

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_LIM_V)
        else $error("used count above capacity limit");

    a_reinit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.func == FN_REINIT |=> count_reg == '0 && mark_reg == '0)
        else $error("reinitialize did not clear count and mark");

endmodule

// File: src/dsa_addr.sv
// Address stages: slot select, slot times stride, base add and response register.
module dsa_addr
    import dsa_pkg::*;
#(
    parameter int ENT_W = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  dsa_s1_t             s1,
    input  logic [ENT_W-1:0]    ram_rdata,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [ADDR_W-1:0]   cpu_base,
    input  logic [ADDR_W-1:0]   gpu_base,
    input  logic                visible,
    output logic                adv,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output dsa_rsp_t            rsp
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                alloc_ok;
        logic [CAP_W-1:0]    slot;
        logic [PROD_W-1:0]   prod;
        logic [CAP_W-1:0]    used;
    } dsa_s2_t;

    logic       s2_valid_reg;
    dsa_s2_t    s2_reg, s2_next;
    logic       out_valid_reg;
    dsa_rsp_t   out_reg, out_next;
    logic       out_en;
    logic       s2_en;
    logic [CAP_W-1:0] slot;

    assign out_en = !out_valid_reg || !rsp_stall;
    assign s2_en  = !s2_valid_reg || out_en;
    assign adv    = s2_en;

    assign slot = s1.from_ram ? CAP_W'(ram_rdata) : s1.pos;

    always_comb
    begin
        s2_next.status   = s1.status;
        s2_next.alloc_ok = s1.alloc_ok;
        s2_next.slot     = slot;
        s2_next.prod     = PROD_W'(slot) * PROD_W'(stride);
        s2_next.used     = s1.used;
    end

    always_comb
    begin
        out_next.status            = s2_reg.status;
        out_next.slot_index        = '0;
        out_next.cpu_address       = '0;
        out_next.gpu_address       = '0;
        out_next.gpu_address_valid = visible;
        out_next.used_count        = s2_reg.used;
        if (s2_reg.alloc_ok)
        begin
            out_next.slot_index  = SLOT_W'(s2_reg.slot);
            out_next.cpu_address = cpu_base + ADDR_W'(s2_reg.prod);
            if (visible)
            begin
                out_next.gpu_address = gpu_base + ADDR_W'(s2_reg.prod);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid)
        begin
            s2_reg <= s2_next;
        end
        if (out_en && s2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: src/descriptor_slot_allocator.sv
// Top level of the descriptor slot allocator: configuration registers and block wiring.
//
// Free-list stack allocator for a table of descriptor slots.
// Request channel (req_valid / req_stall / req): one beat carries func,
// free_index and handle_valid. Allocate pops the slot at the used count,
// free pushes a slot back, reinitialize empties the stack in one beat.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
// request, in request order, with status, slot, host and shader addresses
// and the used count after that request.
// A request passes stage s1, stage s2 and the response register. Throughput: one
// request per cycle while the response is not stalled. Count and fill mark
// update at the accepting edge and the free list has one write and one read
// port, so back-to-back requests never wait on each other.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 capacity,
// 1 stride, 2 host base, 3 shader base, 4 visible, 5 heap kind); write only
// while no request is in flight.
// Reset: count and fill mark clear, registers take their defaults. The free
// list needs no clearing pass; positions at or above the fill mark read as
// their own index.
// Stall: a stalled response holds; the pipeline fills behind it and then
// raises req_stall until the response beat moves.
module descriptor_slot_allocator
    import dsa_pkg::*;
#(
    parameter int CAPACITY_MAX = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  dsa_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output dsa_rsp_t             rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(CAPACITY_MAX);
    localparam int ENT_W = (AW < CAP_W) ? AW : CAP_W;

    logic [CAP_W-1:0]    capacity_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                visible_req_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                visible;

    logic             s1_valid;
    dsa_s1_t          s1;
    logic             adv;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // Register file: take each write beat, ignore indexes past the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_W'(1024);
            stride_reg      <= STRIDE_W'(32);
            cpu_base_reg    <= '0;
            gpu_base_reg    <= '0;
            visible_req_reg <= 1'b0;
            kind_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: capacity_reg    <= cfg_data[CAP_W-1:0];
                CFG_STRIDE:   stride_reg      <= cfg_data[STRIDE_W-1:0];
                CFG_CPU_BASE: cpu_base_reg    <= cfg_data;
                CFG_GPU_BASE: gpu_base_reg    <= cfg_data;
                CFG_VISIBLE:  visible_req_reg <= cfg_data[0];
                CFG_KIND:     kind_reg        <= cfg_data[KIND_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Only view and sampler heaps can be shader visible.
    assign visible = visible_req_reg && (kind_reg == HK_VIEWS || kind_reg == HK_SAMPLERS);

    dsa_ctrl #(
        .CAPACITY_MAX (CAPACITY_MAX)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .capacity_in_use (capacity_reg),
        .adv             (adv),
        .s1_valid        (s1_valid),
        .s1              (s1),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr)
    );

    // Free list: one entry per stack position.
    dsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY_MAX)
    ) u_free_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dsa_addr #(
        .ENT_W (ENT_W)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .ram_rdata (ram_rdata),
        .stride    (stride_reg),
        .cpu_base  (cpu_base_reg),
        .gpu_base  (gpu_base_reg),
        .visible   (visible),
        .adv       (adv),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the descriptor slot allocator: scoreboard, drivers and run sequence.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsa_pkg::*;

    localparam int SLOTS_MAX    = 1024;
    localparam int WATCHDOG_MAX = 2000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES = 6;     // settle time after the last response; leaves margin
    localparam int REPORT_MAX   = 60;    // mismatch lines printed before going quiet

    // func code 3 has no meaning in the block; it must come back as ignored
    localparam logic [FUNC_W-1:0] FN_UNUSED  = 2'd3;
    // heap kinds that never get a shader address
    localparam logic [KIND_W-1:0] HK_TARGETS = 2'd2;
    localparam logic [KIND_W-1:0] HK_DEPTH   = 2'd3;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers, the slot stack,
    // the used count and the fill mark, and predicts one response per
    // accepted request. Responses are checked in order.
    // ------------------------------------------------------------------
    class slot_scoreboard;
        logic [CAP_W-1:0]    capacity;
        logic [STRIDE_W-1:0] stride;
        logic [ADDR_W-1:0]   cpu_base;
        logic [ADDR_W-1:0]   gpu_base;
        logic                visible;
        logic [KIND_W-1:0]   kind;

        logic [SLOT_W-1:0]   stack [SLOTS_MAX];
        int unsigned         used;
        int unsigned         mark;

        dsa_rsp_t            expected_q[$];
        int                  errors;
        int                  checked;

        function new();
            capacity = 11'd1024;
            stride   = 11'd32;
            cpu_base = '0;
            gpu_base = '0;
            visible  = 1'b0;
            kind     = HK_VIEWS;
            used     = 0;
            mark     = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
            case (idx)
                CFG_CAPACITY: capacity = data[CAP_W-1:0];
                CFG_STRIDE:   stride   = data[STRIDE_W-1:0];
                CFG_CPU_BASE: cpu_base = data;
                CFG_GPU_BASE: gpu_base = data;
                CFG_VISIBLE:  visible  = data[0];
                CFG_KIND:     kind     = data[KIND_W-1:0];
                default: ;
            endcase
        endfunction

        // Predict the response of one accepted request and queue it.
        function dsa_rsp_t note_request(dsa_req_t r);
            int unsigned       cap;
            logic              vis;
            logic [SLOT_W-1:0] s;
            logic [PROD_W-1:0] off;
            dsa_rsp_t          e;
            cap = (capacity > SLOTS_MAX) ? SLOTS_MAX : int'(capacity);
            vis = visible && (kind == HK_VIEWS || kind == HK_SAMPLERS);
            e = '0;
            e.status = ST_OK;
            e.gpu_address_valid = vis;
            case (r.func)
                FN_ALLOC:
                    if (used >= cap) begin
                        e.status = ST_FULL;
                    end
                    else begin
                        // at or above the fill mark a position reads as its own index
                        if (used < mark) begin
                            s = stack[used];
                        end
                        else begin
                            s = SLOT_W'(used);
                            stack[used] = s;
                            mark = used + 1;
                        end
                        used = used + 1;
                        off = PROD_W'(s) * PROD_W'(stride);
                        e.slot_index  = s;
                        e.cpu_address = cpu_base + ADDR_W'(off);
                        if (vis)
                            e.gpu_address = gpu_base + ADDR_W'(off);
                    end
                FN_FREE:
                    if (!r.handle_valid) begin
                        e.status = ST_IGNORED;
                    end
                    else if (used == 0) begin
                        e.status = ST_EMPTY;
                    end
                    else if (r.free_index >= cap) begin
                        e.status = ST_RANGE;
                    end
                    else begin
                        used = used - 1;
                        stack[used] = r.free_index;
                    end
                FN_REINIT: begin
                    used = 0;
                    mark = 0;
                end
                default: e.status = ST_IGNORED;
            endcase
            e.used_count = CAP_W'(used);
            expected_q.push_back(e);
            return e;
        endfunction

        function void compare(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        // Check one accepted response beat against the oldest prediction.
        function void check_response(dsa_rsp_t got);
            dsa_rsp_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t ns: response beat with nothing expected, actual %0h",
                             $time, got);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare("status",            ADDR_W'(e.status),            ADDR_W'(got.status));
            compare("slot_index",        ADDR_W'(e.slot_index),        ADDR_W'(got.slot_index));
            compare("cpu_address",       e.cpu_address,                got.cpu_address);
            compare("gpu_address",       e.gpu_address,                got.gpu_address);
            compare("gpu_address_valid", ADDR_W'(e.gpu_address_valid),
                    ADDR_W'(got.gpu_address_valid));
            compare("used_count",        ADDR_W'(e.used_count),        ADDR_W'(got.used_count));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    dsa_req_t             req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    dsa_rsp_t             rsp;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    descriptor_slot_allocator #(
        .CAPACITY_MAX (SLOTS_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    slot_scoreboard    sb;
    int unsigned       send_idle_pct  = 0;   // chance per cycle the request side holds off
    int unsigned       recv_stall_pct = 0;   // chance per cycle the response side stalls
    int                quiet_cycles   = 0;
    int                requests_sent  = 0;
    int                settings_used  = 0;
    logic [SLOT_W-1:0] held_slots[$];        // slots handed out and not yet given back

    // ------------------------------------------------------------------
    // Response side: take beats at the edge, check them, pick the next
    // stall. The watchdog runs here too, counting edges with no beat on
    // either channel.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rsp_valid && !rsp_stall)
            sb.check_response(rsp);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t ns: watchdog expired, %0d responses still outstanding",
                     $time, sb.pending());
            $display("FAILURE");
            $finish;
        end
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    // Send one request beat: idle at random first, then hold the beat
    // until the block takes it. Predict at the accepting edge.
    task automatic send_req(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] idx, logic hv);
        dsa_req_t r;
        dsa_rsp_t e;
        r.func         = f;
        r.free_index   = idx;
        r.handle_valid = hv;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        e = sb.note_request(r);
        requests_sent++;
        // track what the block handed out so frees can return real slots
        if (f == FN_ALLOC && e.status == ST_OK)
            held_slots.push_back(e.slot_index);
        if (f == FN_REINIT)
            held_slots.delete();
    endtask

    // Drop valid and wait until every predicted response has come back,
    // then let the pipeline settle before touching registers.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // Write all six registers back to back. Narrow registers get random
    // junk above their width; the block must keep only the low bits.
    task automatic apply_setting(logic [CAP_W-1:0] cap, logic [STRIDE_W-1:0] stride,
                                 logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu,
                                 logic vis, logic [KIND_W-1:0] kind);
        logic [ADDR_W-1:0] j;
        j = rand48();
        j[CAP_W-1:0] = cap;
        cfg_write(CFG_CAPACITY, j);
        j = rand48();
        j[STRIDE_W-1:0] = stride;
        cfg_write(CFG_STRIDE, j);
        cfg_write(CFG_CPU_BASE, cpu);
        cfg_write(CFG_GPU_BASE, gpu);
        j = rand48();
        j[0] = vis;
        cfg_write(CFG_VISIBLE, j);
        j = rand48();
        j[KIND_W-1:0] = kind;
        cfg_write(CFG_KIND, j);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // One random request. Mostly allocates and frees of slots actually
    // held, with some stray indices, invalid handles, the unused code
    // and the odd reinitialize mixed in.
    task automatic random_request(int unsigned alloc_pct);
        int unsigned       roll;
        int unsigned       k;
        logic [SLOT_W-1:0] idx;
        roll = $urandom_range(0, 99);
        idx  = SLOT_W'($urandom_range(0, SLOTS_MAX - 1));
        if (roll < alloc_pct) begin
            send_req(FN_ALLOC, idx, 1'($urandom_range(0, 1)));
        end
        else if (roll < 90) begin
            if (held_slots.size() != 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, held_slots.size() - 1);
                idx = held_slots[k];
                held_slots.delete(k);
            end
            send_req(FN_FREE, idx, 1'b1);
        end
        else if (roll < 94) begin
            send_req(FN_FREE, idx, 1'b0);
        end
        else if (roll < 97) begin
            send_req(FN_UNUSED, idx, 1'($urandom_range(0, 1)));
        end
        else begin
            send_req(FN_REINIT, idx, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(int n, int unsigned send_pct, int unsigned recv_pct,
                             int unsigned alloc_pct,
                             logic [CAP_W-1:0] cap, logic [STRIDE_W-1:0] stride,
                             logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu,
                             logic vis, logic [KIND_W-1:0] kind);
        wait_idle();
        apply_setting(cap, stride, cpu, gpu, vis, kind);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) random_request(alloc_pct);
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset defaults: plain allocate, the unused code,
        // an invalid handle, a free, then a free with nothing allocated.
        send_req(FN_ALLOC,  10'd0,    1'b0);
        send_req(FN_UNUSED, 10'd0,    1'b1);
        send_req(FN_FREE,   10'd1023, 1'b0);
        send_req(FN_FREE,   10'd0,    1'b1);
        send_req(FN_FREE,   10'd5,    1'b1);

        // Tiny heap with widest stride and bases at the top: addresses wrap.
        // Fill it, overflow it, free out of range, pop a returned slot,
        // then reinitialize back to identity order.
        wait_idle();
        apply_setting(11'd3, 11'd2047, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_F000,
                      1'b1, HK_SAMPLERS);
        send_req(FN_ALLOC,  10'd0, 1'b0);
        send_req(FN_ALLOC,  10'd0, 1'b0);
        send_req(FN_ALLOC,  10'd0, 1'b0);
        send_req(FN_ALLOC,  10'd0, 1'b0);
        send_req(FN_FREE,   10'd3, 1'b1);
        send_req(FN_FREE,   10'd1, 1'b1);
        send_req(FN_FREE,   10'd2, 1'b1);
        send_req(FN_ALLOC,  10'd0, 1'b0);
        send_req(FN_REINIT, 10'd0, 1'b0);
        send_req(FN_ALLOC,  10'd0, 1'b0);

        // Zero capacity and zero stride; render targets drop shader visibility.
        wait_idle();
        apply_setting(11'd0, 11'd0, 48'h0, 48'h0, 1'b1, HK_TARGETS);
        send_req(FN_ALLOC,  10'd0, 1'b0);
        send_req(FN_FREE,   10'd0, 1'b1);
        send_req(FN_REINIT, 10'd0, 1'b0);
        send_req(FN_FREE,   10'd0, 1'b1);

        // Capacity above the table size clamps to the table; top slot index.
        wait_idle();
        apply_setting(11'd2047, 11'd1024, rand48(), rand48(), 1'b1, HK_VIEWS);
        send_req(FN_ALLOC,  10'd0,    1'b0);
        send_req(FN_FREE,   10'd1023, 1'b1);
        send_req(FN_ALLOC,  10'd0,    1'b0);
        send_req(FN_FREE,   10'd512,  1'b0);
        send_req(FN_ALLOC,  10'd0,    1'b0);
        send_req(FN_REINIT, 10'd0,    1'b0);

        // Random phases; state carries over, so a lowered capacity often
        // starts below the current count.
        run_phase(250, 0, 0, 50, 11'd16, 11'd32, rand48(), rand48(), 1'b1, HK_VIEWS);
        run_phase(250, 61, 0, 55, 11'd5, 11'd2047, 48'hFFFF_FFFF_FF00, 48'hFFFF_FFFF_FFFF,
                  1'b1, HK_SAMPLERS);
        run_phase(200, 0, 61, 75, 11'd1024, 11'd1, rand48(), rand48(), 1'b1, HK_TARGETS);
        run_phase(150, 10, 10, 45, 11'd2, 11'd0, 48'h0, rand48(), 1'b0, HK_VIEWS);
        run_phase(200, 0, 0, 60, 11'd2047, STRIDE_W'($urandom_range(1, 2047)),
                  rand48(), rand48(), 1'b1, HK_DEPTH);
        run_phase(150, 0, 61, 50, 11'd1, 11'd1024, rand48(), 48'h0, 1'b1, HK_VIEWS);
        run_phase(200, 61, 0, 55, 11'd100, STRIDE_W'($urandom_range(0, 2047)),
                  rand48(), rand48(), 1'($urandom_range(0, 1)),
                  KIND_W'($urandom_range(0, 3)));
        run_phase(150, 10, 10, 50, 11'd33, 11'd7, rand48(), rand48(), 1'b1, HK_SAMPLERS);

        wait_idle();
        $display("Covered %0d requests under %0d register settings with mixed idling and stalls;",
                 requests_sent, settings_used);
        $display("%0d responses checked, %0d field mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
